// ===== hdl/roman_numeral_encoder_assert.svh =====
// assertion macros shared by the queue and back-end modules
`ifndef ROMAN_NUMERAL_ENCODER_ASSERT_SVH
`define ROMAN_NUMERAL_ENCODER_ASSERT_SVH

// same-cycle implication
`define RNE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RNE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rne_pkg.sv =====
`default_nettype none
package rne_pkg;

	localparam int unsigned ValueW     = 12;
	localparam int unsigned CharW      = 7;
	localparam int unsigned NumPlaces  = 4;
	localparam int unsigned DigitW     = 4;
	localparam int unsigned PlaceW     = 2;
	localparam int unsigned PosW       = 2;
	localparam int unsigned LenW       = 3;
	localparam int unsigned LetterW    = 3;
	localparam int unsigned RomanMax   = 3999;
	localparam int unsigned QueueDepth = 2;

	localparam logic [CharW-1:0] AsciiZero = 7'h30;
	localparam logic [CharW-1:0] NoChar    = 7'h00;

	typedef logic [DigitW-1:0] digit_t;
	typedef logic [NumPlaces-1:0][DigitW-1:0] digits_t;

	typedef struct packed {
		logic    roman;
		logic    oor;
		digits_t digits;
	} item_t;

	typedef struct packed {
		digit_t            digit;
		logic [ValueW-1:0] rem;
	} dstep_t;

	typedef enum logic [1:0] {FE_IDLE, FE_CONV, FE_PUSH} fe_state_t;
	typedef enum logic {BE_IDLE, BE_RUN} be_state_t;
	typedef enum logic [1:0] {SYM_ONE, SYM_FIVE, SYM_TEN} sym_t;

	// one decimal digit of rem at the given place, by parallel compares
	function automatic dstep_t digit_step(input logic [ValueW-1:0] rem,
			input logic [PlaceW-1:0] place);
		logic [ValueW+1:0] thr;
		logic [ValueW+1:0] sub;
		dstep_t            r;
		r.digit = '0;
		sub     = '0;
		for (int k = 1; k < 10; k++) begin
			unique case (place)
				2'd0: thr = (ValueW+2)'(k);
				2'd1: thr = (ValueW+2)'(k * 10);
				2'd2: thr = (ValueW+2)'(k * 100);
				default: thr = (ValueW+2)'(k * 1000);
			endcase
			if ({2'b00, rem} >= thr) begin
				r.digit = DigitW'(k);
				sub     = thr;
			end
		end
		r.rem = rem - sub[ValueW-1:0];
		return r;
	endfunction

	function automatic logic [LenW-1:0] rom_len(input digit_t d);
		logic [LenW-1:0] l;
		unique case (d)
			4'd1, 4'd5:       l = 3'd1;
			4'd2, 4'd4, 4'd6,
			4'd9:             l = 3'd2;
			4'd3, 4'd7:       l = 3'd3;
			4'd8:             l = 3'd4;
			default:          l = 3'd0;
		endcase
		return l;
	endfunction

	function automatic sym_t rom_sym(input digit_t d, input logic [PosW-1:0] pos);
		sym_t s;
		if (d == 4'd4) begin
			s = (pos == '0) ? SYM_ONE : SYM_FIVE;
		end else if (d == 4'd9) begin
			s = (pos == '0) ? SYM_ONE : SYM_TEN;
		end else if (d >= 4'd5) begin
			s = (pos == '0) ? SYM_FIVE : SYM_ONE;
		end else begin
			s = SYM_ONE;
		end
		return s;
	endfunction

	function automatic logic [CharW-1:0] roman_letter(input logic [LetterW-1:0] idx);
		logic [CharW-1:0] c;
		unique case (idx)
			3'd0: c = 7'h49;
			3'd1: c = 7'h56;
			3'd2: c = 7'h58;
			3'd3: c = 7'h4C;
			3'd4: c = 7'h43;
			3'd5: c = 7'h44;
			3'd6: c = 7'h4D;
			default: c = 7'h2D;
		endcase
		return c;
	endfunction

	// highest nonzero place, zero when all digits are zero
	function automatic logic [PlaceW-1:0] lead_place(input digits_t dg);
		logic [PlaceW-1:0] p;
		p = '0;
		for (int k = 0; k < NumPlaces; k++) begin
			if (dg[k] != '0) begin
				p = PlaceW'(k);
			end
		end
		return p;
	endfunction

	function automatic logic lower_zero(input digits_t dg, input logic [PlaceW-1:0] place);
		logic z;
		z = 1'b1;
		for (int k = 0; k < NumPlaces; k++) begin
			if ((PlaceW'(k) < place) && (dg[k] != '0)) begin
				z = 1'b0;
			end
		end
		return z;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/rne_front.sv =====
`default_nettype none
module rne_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [rne_pkg::ValueW-1:0]   value,
	input  wire logic                         roman_mode,
	output logic                              busy,
	output logic                              push,
	output rne_pkg::item_t                    push_item,
	input  wire logic                         full
);

	rne_pkg::fe_state_t                state_q, state_nx;
	logic [rne_pkg::PlaceW-1:0]        place_q;
	logic [rne_pkg::ValueW-1:0]        rem_q;
	rne_pkg::digits_t                  digits_q;
	logic                              roman_q;
	logic                              oor_q;
	rne_pkg::dstep_t                   step;
	logic                              take;

	assign take = (state_q == rne_pkg::FE_IDLE) && start;
	assign step = rne_pkg::digit_step(rem_q, place_q);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			rne_pkg::FE_IDLE: if (start) state_nx = rne_pkg::FE_CONV;
			rne_pkg::FE_CONV: if (place_q == '0) state_nx = rne_pkg::FE_PUSH;
			rne_pkg::FE_PUSH: if (!full) state_nx = rne_pkg::FE_IDLE;
			default: state_nx = rne_pkg::FE_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != rne_pkg::FE_IDLE);
		push = (state_q == rne_pkg::FE_PUSH) && !full;
		push_item.roman  = roman_q;
		push_item.oor    = oor_q;
		push_item.digits = digits_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rne_pkg::FE_IDLE;
			place_q <= '0;
		end else begin
			state_q <= state_nx;
			if (take) begin
				place_q <= rne_pkg::PlaceW'(rne_pkg::NumPlaces - 1);
			end else if (state_q == rne_pkg::FE_CONV) begin
				place_q <= place_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rem_q   <= value;
			roman_q <= roman_mode;
			oor_q   <= roman_mode &&
				((value == '0) || (value > rne_pkg::ValueW'(rne_pkg::RomanMax)));
		end else if (state_q == rne_pkg::FE_CONV) begin
			digits_q[place_q] <= step.digit;
			rem_q             <= step.rem;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/rne_queue.sv =====
`default_nettype none
`include "roman_numeral_encoder_assert.svh"
module rne_queue #(
	parameter int unsigned DEPTH = rne_pkg::QueueDepth
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire rne_pkg::item_t  push_item,
	output logic                 full,
	input  wire logic            pop,
	output rne_pkg::item_t       pop_item,
	output logic                 empty
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	rne_pkg::item_t   mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign full     = (count_q == CntW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`RNE_ASSERT_NOW(a_no_overflow, push, !full, "transfer into a full queue")
	`RNE_ASSERT_NOW(a_no_underflow, pop, !empty, "read from an empty queue")

endmodule
`default_nettype wire

// ===== hdl/rne_back.sv =====
`default_nettype none
`include "roman_numeral_encoder_assert.svh"
module rne_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        empty,
	input  wire rne_pkg::item_t              pop_item,
	output logic                             pop,
	output logic                             valid,
	output logic [rne_pkg::CharW-1:0]        char_code,
	output logic                             last_char,
	output logic                             out_of_range
);

	rne_pkg::be_state_t            state_q, state_nx;
	rne_pkg::item_t                item_q;
	logic [rne_pkg::PlaceW-1:0]    place_q;
	logic [rne_pkg::PosW-1:0]      pos_q;
	logic                          valid_q;
	logic [rne_pkg::CharW-1:0]     char_q;
	logic                          last_q;
	logic                          oor_q;

	rne_pkg::digit_t               d;
	logic [rne_pkg::LenW-1:0]      len;
	rne_pkg::sym_t                 sym;
	logic [rne_pkg::CharW-1:0]     letter;
	logic                          lz;
	logic                          run;
	logic                          emit;
	logic                          e_last;
	logic [rne_pkg::CharW-1:0]     e_char;
	logic                          dig_done;

	always_comb begin
		d      = item_q.digits[place_q];
		len    = rne_pkg::rom_len(d);
		sym    = rne_pkg::rom_sym(d, pos_q);
		letter = rne_pkg::roman_letter(rne_pkg::LetterW'({place_q, 1'b0}) +
			rne_pkg::LetterW'(sym));
		lz     = rne_pkg::lower_zero(item_q.digits, place_q);
		run    = (state_q == rne_pkg::BE_RUN);
		if (item_q.oor) begin
			emit     = 1'b1;
			e_char   = rne_pkg::NoChar;
			e_last   = 1'b1;
			dig_done = 1'b1;
		end else if (item_q.roman) begin
			emit     = (len != '0);
			e_char   = letter;
			e_last   = (rne_pkg::LenW'(pos_q) + 1'b1 == len) && lz;
			dig_done = (len == '0) || (rne_pkg::LenW'(pos_q) + 1'b1 == len);
		end else begin
			emit     = 1'b1;
			e_char   = rne_pkg::AsciiZero + rne_pkg::CharW'(d);
			e_last   = (place_q == '0);
			dig_done = 1'b1;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			rne_pkg::BE_IDLE: if (!empty) state_nx = rne_pkg::BE_RUN;
			rne_pkg::BE_RUN:  if (emit && e_last) state_nx = rne_pkg::BE_IDLE;
			default: state_nx = rne_pkg::BE_IDLE;
		endcase
	end

	always_comb begin
		pop          = (state_q == rne_pkg::BE_IDLE) && !empty;
		valid        = valid_q;
		char_code    = char_q;
		last_char    = last_q;
		out_of_range = oor_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rne_pkg::BE_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			valid_q <= run && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q  <= pop_item;
			place_q <= pop_item.roman ? rne_pkg::PlaceW'(rne_pkg::NumPlaces - 1)
				: rne_pkg::lead_place(pop_item.digits);
			pos_q   <= '0;
		end else if (run) begin
			if (dig_done) begin
				place_q <= place_q - 1'b1;
				pos_q   <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
		char_q <= e_char;
		last_q <= e_last;
		oor_q  <= item_q.oor;
	end

	`RNE_ASSERT_NOW(a_oor_single, valid_q && oor_q, last_q && (char_q == rne_pkg::NoChar), "bad oor")
	`RNE_ASSERT_NEXT(a_pop_runs, pop, state_q == rne_pkg::BE_RUN, "queue read without run")

endmodule
`default_nettype wire

// ===== hdl/roman_numeral_encoder.sv =====
`default_nettype none
// Converts one 12-bit value per start into ASCII text, one character per
// valid cycle, with last_char on the final one. roman_mode selects roman
// numerals (1 to 3999, otherwise one transfer with char_code 0, last_char and
// out_of_range set) or decimal digits without leading zeros. The receiver
// cannot stall: each character is on the outputs for exactly one cycle.
// The front end accepts a value, converts one digit per cycle over four
// places and hands it to the queue; the back end emits the characters, steps
// over each zero digit ahead of the last nonzero digit in roman mode and then
// fetches the next value from the queue. The two overlap: the front end can
// convert a new value while the back end still emits the previous one's text.
module roman_numeral_encoder #(
	parameter int unsigned QUEUE_DEPTH = rne_pkg::QueueDepth
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         roman_mode_we,
	input  wire logic                         roman_mode_wd,
	input  wire logic                         start,
	input  wire logic [rne_pkg::ValueW-1:0]   value,
	output logic                              busy,
	output logic                              valid,
	output logic [rne_pkg::CharW-1:0]         char_code,
	output logic                              last_char,
	output logic                              out_of_range
);

	logic            roman_mode_q;
	logic            push;
	logic            full;
	logic            pop;
	logic            empty;
	rne_pkg::item_t  push_item;
	rne_pkg::item_t  pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roman_mode_q <= 1'b0;
		end else if (roman_mode_we) begin
			roman_mode_q <= roman_mode_wd;
		end
	end

	rne_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.value      (value),
		.roman_mode (roman_mode_q),
		.busy       (busy),
		.push       (push),
		.push_item  (push_item),
		.full       (full)
	);

	rne_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (empty)
	);

	rne_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.pop_item     (pop_item),
		.pop          (pop),
		.valid        (valid),
		.char_code    (char_code),
		.last_char    (last_char),
		.out_of_range (out_of_range)
	);

endmodule
`default_nettype wire

// ===== bench/roman_text_checker.sv =====
module roman_text_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       roman_mode_we,
	input  logic                       roman_mode_wd,
	input  logic                       start,
	input  logic                       busy,
	input  logic [rne_pkg::ValueW-1:0] value,
	input  logic                       valid,
	input  logic [rne_pkg::CharW-1:0]  char_code,
	input  logic                       last_char,
	input  logic                       out_of_range,
	output int                         errors,
	output int                         pending
);
	import rne_pkg::*;

	typedef struct packed {
		logic [CharW-1:0] code;
		logic             last;
		logic             oor;
	} text_char_t;

	string      glyphs = "IVXLCDM--";
	logic       roman;
	text_char_t pending_text[$];
	text_char_t want;

	// expected characters of one value, appended to the queue of pending text
	function automatic void spell_value(input logic [ValueW-1:0] v, input logic in_roman);
		int         rest;
		int         scale;
		int         place;
		int         d;
		logic [7:0] one;
		logic [7:0] five;
		logic [7:0] ten;
		logic [7:0] txt[$];
		text_char_t c;
		rest = v;
		if (in_roman) begin
			if (v == 0 || v > RomanMax) begin
				c.code = NoChar;
				c.last = 1'b1;
				c.oor  = 1'b1;
				pending_text.push_back(c);
				return;
			end
			scale = 1000;
			for (place = 3; place >= 0; place--) begin
				d     = rest / scale;
				rest  = rest % scale;
				one   = glyphs[2 * place];
				five  = glyphs[2 * place + 1];
				ten   = glyphs[2 * place + 2];
				if (d == 4) begin
					txt.push_back(one);
					txt.push_back(five);
				end else if (d == 9) begin
					txt.push_back(one);
					txt.push_back(ten);
				end else begin
					if (d >= 5) begin
						txt.push_back(five);
						d -= 5;
					end
					repeat (d) txt.push_back(one);
				end
				scale = scale / 10;
			end
		end else begin
			do begin
				txt.push_front(8'h30 + 8'(rest % 10));
				rest = rest / 10;
			end while (rest != 0);
		end
		for (int n = 0; n < txt.size(); n++) begin
			c.code = txt[n][CharW-1:0];
			c.last = (n == txt.size() - 1);
			c.oor  = 1'b0;
			pending_text.push_back(c);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roman   <= 1'b0;
			errors  <= 0;
			pending <= 0;
			pending_text.delete();
		end else begin
			if (valid) begin
				if (pending_text.size() == 0) begin
					$display("%0t unexpected transfer: char %h last %b oor %b", $time,
						char_code, last_char, out_of_range);
					errors <= errors + 1;
				end else begin
					want = pending_text.pop_front();
					if (want.code !== char_code || want.last !== last_char ||
							want.oor !== out_of_range) begin
						$display("%0t mismatch: expected char %h last %b oor %b, got char %h last %b oor %b",
							$time, want.code, want.last, want.oor,
							char_code, last_char, out_of_range);
						errors <= errors + 1;
					end
				end
			end
			if (start && !busy) begin
				spell_value(value, roman);
			end
			if (roman_mode_we) begin
				roman <= roman_mode_wd;
			end
			pending <= pending_text.size();
		end
	end

endmodule

// ===== bench/tb_roman_numeral_encoder.sv =====
module tb_roman_numeral_encoder;
	import rne_pkg::*;

	localparam logic DecimalMode = 1'b0;
	localparam logic RomanMode   = 1'b1;
	localparam int   CycleLimit  = 400000;
	localparam int   NumPhases   = 8;
	localparam int   PhaseItems  = 57;

	logic              clk;
	logic              arst_n;
	logic              roman_mode_we;
	logic              roman_mode_wd;
	logic              start;
	logic [ValueW-1:0] value;
	logic              busy;
	logic              valid;
	logic [CharW-1:0]  char_code;
	logic              last_char;
	logic              out_of_range;
	int                errors;
	int                pending;
	int                cycles = 0;
	bit                steady;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	roman_numeral_encoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.roman_mode_we(roman_mode_we),
		.roman_mode_wd(roman_mode_wd),
		.start        (start),
		.value        (value),
		.busy         (busy),
		.valid        (valid),
		.char_code    (char_code),
		.last_char    (last_char),
		.out_of_range (out_of_range)
	);

	roman_text_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.roman_mode_we(roman_mode_we),
		.roman_mode_wd(roman_mode_wd),
		.start        (start),
		.busy         (busy),
		.value        (value),
		.valid        (valid),
		.char_code    (char_code),
		.last_char    (last_char),
		.out_of_range (out_of_range),
		.errors       (errors),
		.pending      (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("FAIL roman_numeral_encoder");
			$finish;
		end
	end

	// one value transfer, after a random gap unless steady is set
	task automatic send_value(input logic [ValueW-1:0] v);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 17);
		@(negedge clk);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
		start = 1'b1;
		value = v;
		do @(posedge clk); while (busy);
	endtask

	// hold off until every expected character has come out
	task automatic drain();
		@(negedge clk);
		start = 1'b0;
		while (pending != 0 || busy) @(negedge clk);
	endtask

	task automatic set_mode(input logic m);
		drain();
		@(negedge clk);
		roman_mode_we = 1'b1;
		roman_mode_wd = m;
		@(negedge clk);
		roman_mode_we = 1'b0;
	endtask

	function automatic logic [ValueW-1:0] pick_roman();
		logic [ValueW-1:0] v;
		case ($urandom_range(0, 19))
			0: v = '0;
			1, 2: v = ValueW'($urandom_range(4000, 4095));
			3, 4, 5, 6, 7: v = ValueW'(1000 * $urandom_range(0, 3) + 100 * $urandom_range(0, 9) +
				10 * $urandom_range(0, 9) + $urandom_range(0, 9));
			default: v = ValueW'($urandom_range(1, 3999));
		endcase
		return v;
	endfunction

	function automatic logic [ValueW-1:0] pick_decimal();
		logic [ValueW-1:0] v;
		case ($urandom_range(0, 7))
			0: v = ValueW'($urandom_range(0, 9));
			1: v = ValueW'($urandom_range(10, 999));
			default: v = ValueW'($urandom_range(0, 4095));
		endcase
		return v;
	endfunction

	initial begin
		logic mode;
		arst_n        = 1'b0;
		roman_mode_we = 1'b0;
		roman_mode_wd = 1'b0;
		start         = 1'b0;
		value         = '0;
		steady        = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// decimal after reset
		send_value(12'd0);
		send_value(12'd4095);
		send_value(12'd9);
		send_value(12'd10);
		send_value(12'd999);
		send_value(12'd1000);
		send_value(12'd2048);
		set_mode(RomanMode);
		send_value(12'd0);
		send_value(12'd1);
		send_value(12'd4);
		send_value(12'd9);
		send_value(12'd3999);
		send_value(12'd4000);
		send_value(12'd4095);
		send_value(12'd3888);
		send_value(12'd1444);
		send_value(12'd2949);
		send_value(12'd494);
		send_value(12'd40);
		send_value(12'd90);
		set_mode(RomanMode);
		send_value(12'd3333);
		set_mode(DecimalMode);
		send_value(12'd7);

		for (int phase = 0; phase < NumPhases; phase++) begin
			if (phase < 2) begin
				mode = phase[0] ? DecimalMode : RomanMode;
			end else begin
				mode = logic'($urandom_range(0, 1));
			end
			set_mode(mode);
			steady = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PhaseItems; k++) begin
				if (!steady && $urandom_range(0, 15) == 0) begin
					steady = 1'b1;
				end else if (steady && $urandom_range(0, 9) == 0) begin
					steady = 1'b0;
				end
				send_value(mode == RomanMode ? pick_roman() : pick_decimal());
			end
			steady = 1'b0;
		end

		drain();
		repeat (24) @(negedge clk);
		if (errors == 0) begin
			$display("PASS roman_numeral_encoder");
		end else begin
			$display("FAIL roman_numeral_encoder");
		end
		$finish;
	end

endmodule
